[design/lsw_pkg.sv]
// Package for the lap stopwatch: command codes, sizes and the
// controller/datapath command and status structs. No dependencies.
package lsw_pkg;

  localparam int unsigned LapDepth = 64;
  localparam int unsigned LapAddrW = (LapDepth > 1) ? $clog2(LapDepth) : 1;
  localparam int unsigned OpW      = 3;
  localparam int unsigned IdxW     = 11;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 7;

  localparam logic [OpW-1:0] OpTick  = 3'd0;
  localparam logic [OpW-1:0] OpStart = 3'd1;
  localparam logic [OpW-1:0] OpStop  = 3'd2;
  localparam logic [OpW-1:0] OpLap   = 3'd3;
  localparam logic [OpW-1:0] OpClear = 3'd4;
  localparam logic [OpW-1:0] OpRead  = 3'd5;

  localparam logic [TimeW-1:0] TimeAllOnes = {TimeW{1'b1}};

  typedef struct packed {
    logic exec;         // item accepted: update the watch state
    logic mem_rd;       // item accepted and it reads a stored lap
    logic load_direct;  // load the result register from the current item
    logic load_mem;     // load the result register from the lap memory
  } lsw_cmd_t;

  typedef struct packed {
    logic lap_read;     // offered item is a read of a stored lap
  } lsw_sts_t;

endpackage

[design/lsw_if.sv]
// Handshake interfaces for the lap stopwatch command and result channels.
// Depends on lsw_pkg.
interface lsw_in_if;
  import lsw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         opcode;
  logic signed [IdxW-1:0] lap_index;

  modport source (output valid, output opcode, output lap_index, input ready);
  modport sink (input valid, input opcode, input lap_index, output ready);
endinterface

interface lsw_out_if;
  import lsw_pkg::*;
  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  time_value;
  logic              value_valid;
  logic              accepted;
  logic              is_stopped;
  logic [CountW-1:0] lap_total;

  modport source (output valid, output time_value, output value_valid,
                  output accepted, output is_stopped, output lap_total,
                  input ready);
  modport sink (input valid, input time_value, input value_valid,
                input accepted, input is_stopped, input lap_total,
                output ready);
endinterface

[design/lap_stopwatch_core.sv]
// Top level of the lap stopwatch: joins lsw_ctrl and lsw_datapath to the
// command and result channels. Depends on lsw_pkg and lsw_if.
//
//   Port   Dir  Interface   Payload
//   in_i   in   lsw_in_if   opcode, lap_index
//   out_o  out  lsw_out_if  time_value, value_valid, accepted, is_stopped,
//                           lap_total
//
// With the result side ready and no read of a stored lap in flight, one item
// is taken per cycle. A read of a stored lap passes through the registered
// read port of the lap memory and then the result register, and no item is
// taken while its data comes back.
// While a result waits in the output register, the next item is taken only in
// the cycle in which that result is taken.
// Reset is asynchronous; it zeroes the counter, stop flag and count and sets
// the capture to all ones.
module lap_stopwatch_core (
  input  logic clk_i,
  input  logic rst_ni,
  lsw_in_if.sink    in_i,
  lsw_out_if.source out_o
);
  import lsw_pkg::*;

  lsw_cmd_t cmd;
  lsw_sts_t sts;

  lsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (in_i.opcode),
    .lap_index_i   (in_i.lap_index),
    .time_value_o  (out_o.time_value),
    .value_valid_o (out_o.value_valid),
    .accepted_o    (out_o.accepted),
    .is_stopped_o  (out_o.is_stopped),
    .lap_total_o   (out_o.lap_total)
  );

endmodule

[design/lsw_datapath.sv]
// Datapath of the lap stopwatch: counter, stop capture, lap memory and the
// result register. Depends on lsw_pkg; driven by lsw_ctrl.
module lsw_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lsw_pkg::lsw_cmd_t              cmd_i,
  output lsw_pkg::lsw_sts_t              sts_o,
  input  logic [lsw_pkg::OpW-1:0]        opcode_i,
  input  logic signed [lsw_pkg::IdxW-1:0] lap_index_i,
  output logic [lsw_pkg::TimeW-1:0]      time_value_o,
  output logic                           value_valid_o,
  output logic                           accepted_o,
  output logic                           is_stopped_o,
  output logic [lsw_pkg::CountW-1:0]     lap_total_o
);
  import lsw_pkg::*;

  logic [TimeW-1:0]  elapsed_q, elapsed_d;
  logic              stopped_q, stopped_d;
  logic [TimeW-1:0]  captured_q, captured_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  rd_data_q;
  logic [TimeW-1:0]  lap_mem [LapDepth];

  logic [TimeW-1:0]  res_time_q;
  logic              res_valid_q, res_acc_q, res_stopped_q;
  logic [CountW-1:0] res_total_q;

  logic [TimeW-1:0]  cur_time;
  logic              lap_ok, lap_hit, lap_wr;
  logic [TimeW-1:0]  res_time;
  logic              res_valid, res_acc;

  assign cur_time = stopped_q ? captured_q : elapsed_q;
  assign lap_ok   = !stopped_q && (count_q < CountW'(LapDepth));
  // Index bits below the sign, compared against the stored lap count.
  assign lap_hit  = !lap_index_i[IdxW-1] &&
                    ({{(IdxW-1-CountW){1'b0}}, count_q} > lap_index_i[IdxW-2:0]);
  assign sts_o.lap_read = (opcode_i == OpRead) && lap_hit;
  assign lap_wr   = cmd_i.exec && (opcode_i == OpLap) && lap_ok;

  always_comb begin
    elapsed_d  = elapsed_q;
    stopped_d  = stopped_q;
    captured_d = captured_q;
    count_d    = count_q;
    res_time   = '0;
    res_valid  = 1'b0;
    res_acc    = 1'b1;
    unique case (opcode_i)
      OpTick: begin
        if (elapsed_q != TimeAllOnes) elapsed_d = elapsed_q + 1'b1;
      end
      OpStart: begin
        stopped_d = 1'b0;
        elapsed_d = '0;
      end
      OpStop: begin
        if (!stopped_q) begin
          stopped_d  = 1'b1;
          captured_d = elapsed_q;
        end
      end
      OpLap: begin
        if (lap_ok) begin
          count_d   = count_q + 1'b1;
          elapsed_d = '0;
        end else begin
          res_acc = 1'b0;
        end
      end
      OpClear: count_d = '0;
      OpRead: begin
        // A stored-lap hit goes through the memory and is not loaded here.
        if (lap_index_i[IdxW-1]) begin
          res_time  = cur_time;
          res_valid = 1'b1;
        end else begin
          res_time  = TimeAllOnes;
          res_valid = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      stopped_q  <= 1'b0;
      captured_q <= TimeAllOnes;
      count_q    <= '0;
    end else if (cmd_i.exec) begin
      elapsed_q  <= elapsed_d;
      stopped_q  <= stopped_d;
      captured_q <= captured_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lap_wr) lap_mem[count_q[LapAddrW-1:0]] <= elapsed_q;
    if (cmd_i.mem_rd) rd_data_q <= lap_mem[lap_index_i[LapAddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_direct) begin
      res_time_q    <= res_time;
      res_valid_q   <= res_valid;
      res_acc_q     <= res_acc;
      res_stopped_q <= stopped_d;
      res_total_q   <= count_d;
    end else if (cmd_i.load_mem) begin
      res_time_q    <= rd_data_q;
      res_valid_q   <= 1'b1;
      res_acc_q     <= 1'b1;
      res_stopped_q <= stopped_q;
      res_total_q   <= count_q;
    end
  end

  assign time_value_o  = res_time_q;
  assign value_valid_o = res_valid_q;
  assign accepted_o    = res_acc_q;
  assign is_stopped_o  = res_stopped_q;
  assign lap_total_o   = res_total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(LapDepth))
    else $error("lap count beyond the store depth");

  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (opcode_i == OpTick) && (elapsed_q == TimeAllOnes)
    |=> elapsed_q == TimeAllOnes)
    else $error("elapsed counter wrapped");

  a_capture_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(captured_q) |-> $past(cmd_i.exec && (opcode_i == OpStop)))
    else $error("captured time changed without a stop");

endmodule

[design/lsw_ctrl.sv]
// Controller of the lap stopwatch: handshakes and sequencing of lap reads
// through the registered memory port. Depends on lsw_pkg.
module lsw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lsw_pkg::lsw_sts_t sts_i,
  output lsw_pkg::lsw_cmd_t cmd_o
);
  import lsw_pkg::*;

  localparam logic StIdle  = 1'b0;
  localparam logic StMemRd = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  // A new item may enter when no lap read is in flight and the result register is empty or is being taken.
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.exec        = accept;
    cmd_o.mem_rd      = accept && sts_i.lap_read;
    cmd_o.load_direct = accept && !sts_i.lap_read;
    cmd_o.load_mem    = (state_q == StMemRd);
    state_d           = state_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.lap_read) begin
            state_d = StMemRd;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      StMemRd: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_memrd_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMemRd) |-> !out_valid_q)
    else $error("memory read finishing while a result is still held");

  a_memrd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMemRd) |=> out_valid_q && (state_q == StIdle))
    else $error("lap read did not deliver its result");

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_direct |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule

[sim/lap_stopwatch_checker.sv]
// Checker for the lap stopwatch: watches the command and result channels,
// keeps its own copy of the watch state and compares every result in order.
// Depends on lsw_pkg and lsw_if.
module lap_stopwatch_checker
  import lsw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lsw_in_if    cmd_i,
  lsw_out_if   res_i,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o
);

  typedef struct packed {
    logic [TimeW-1:0]  time_value;
    logic              value_valid;
    logic              accepted;
    logic              is_stopped;
    logic [CountW-1:0] lap_total;
  } watch_reading_t;

  logic [TimeW-1:0]  elapsed_ms;
  logic [TimeW-1:0]  captured_ms;
  logic              stopped;
  logic [CountW-1:0] laps_held;
  logic [TimeW-1:0]  lap_times [LapDepth];

  watch_reading_t expected_readings [$];
  int mismatches = 0;
  int pending    = 0;

  assign mismatch_cnt_o = mismatches;
  assign pending_cnt_o  = pending;

  task automatic report_mismatch(input string what, input logic [TimeW-1:0] got,
                                 input logic [TimeW-1:0] want);
    mismatches++;
    $display("checker: %s mismatch, got %0h, expected %0h, at %0t",
             what, got, want, $time);
  endtask

  // Applies one command to the watch state and works out the reading it gives.
  task automatic step_watch(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                            output watch_reading_t reading);
    reading = '0;
    reading.accepted = 1'b1;
    case (op)
      OpTick: begin
        if (elapsed_ms != TimeAllOnes) elapsed_ms = elapsed_ms + 1'b1;
      end
      OpStart: begin
        stopped    = 1'b0;
        elapsed_ms = '0;
      end
      OpStop: begin
        if (!stopped) begin
          stopped     = 1'b1;
          captured_ms = elapsed_ms;
        end
      end
      OpLap: begin
        if (!stopped && laps_held < CountW'(LapDepth)) begin
          lap_times[laps_held[LapAddrW-1:0]] = elapsed_ms;
          laps_held            = laps_held + 1'b1;
          elapsed_ms           = '0;
        end else begin
          reading.accepted = 1'b0;
        end
      end
      OpClear: begin
        laps_held = '0;
      end
      OpRead: begin
        // Any negative index reads the current time.
        if (idx[IdxW-1]) begin
          reading.time_value  = stopped ? captured_ms : elapsed_ms;
          reading.value_valid = 1'b1;
        end else if (idx < IdxW'(laps_held) && idx < IdxW'(LapDepth)) begin
          reading.time_value  = lap_times[idx[LapAddrW-1:0]];
          reading.value_valid = 1'b1;
        end else begin
          reading.time_value = TimeAllOnes;
        end
      end
      default: ;
    endcase
    reading.is_stopped = stopped;
    reading.lap_total  = laps_held;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_model
    watch_reading_t seen;
    watch_reading_t want;
    watch_reading_t next_reading;
    if (!rst_ni) begin
      elapsed_ms  = '0;
      captured_ms = TimeAllOnes;
      stopped     = 1'b0;
      laps_held   = '0;
      expected_readings.delete();
      pending = 0;
    end else begin
      // A result never leaves in the cycle its item is taken, so the oldest
      // expectation is settled before this edge's item is predicted.
      if (res_i.valid && res_i.ready) begin
        seen.time_value  = res_i.time_value;
        seen.value_valid = res_i.value_valid;
        seen.accepted    = res_i.accepted;
        seen.is_stopped  = res_i.is_stopped;
        seen.lap_total   = res_i.lap_total;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result", seen.time_value, '0);
        end else begin
          want = expected_readings.pop_front();
          if (seen.time_value !== want.time_value)
            report_mismatch("time_value", seen.time_value, want.time_value);
          if (seen.value_valid !== want.value_valid)
            report_mismatch("value_valid", TimeW'(seen.value_valid),
                            TimeW'(want.value_valid));
          if (seen.accepted !== want.accepted)
            report_mismatch("accepted", TimeW'(seen.accepted), TimeW'(want.accepted));
          if (seen.is_stopped !== want.is_stopped)
            report_mismatch("is_stopped", TimeW'(seen.is_stopped),
                            TimeW'(want.is_stopped));
          if (seen.lap_total !== want.lap_total)
            report_mismatch("lap_total", TimeW'(seen.lap_total),
                            TimeW'(want.lap_total));
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        step_watch(cmd_i.opcode, cmd_i.lap_index, next_reading);
        expected_readings.insert(expected_readings.size(), next_reading);
      end
      pending = expected_readings.size();
    end
  end

endmodule

[sim/lap_stopwatch_core_tb.sv]
// Testbench top for lap_stopwatch_core: drives directed and random command
// items under varying idle and stall patterns and gives the verdict.
// Depends on lsw_pkg, lsw_if, lap_stopwatch_core and lap_stopwatch_checker.
module lap_stopwatch_core_tb;
  import lsw_pkg::*;

  // Codes 6 and 7 are not commands; the block treats them as no-ops.
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  localparam int unsigned ItemTarget = 950;
  localparam int unsigned CycleLimit = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lsw_in_if  cmd_if ();
  lsw_out_if res_if ();

  int mismatch_cnt;
  int pending_cnt;
  int unsigned cycle_cnt      = 0;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  lap_stopwatch_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  lap_stopwatch_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Phases: no idling, sender idle, receiver stalling, both.
  function automatic void set_phase(input int unsigned phase);
    send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 23 : 0;
    recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 23 : 0;
  endfunction

  // Mostly the current time or low lap numbers, now and then anything at all.
  function automatic logic [IdxW-1:0] pick_index(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return '1;
    if (roll < 35) return {1'b1, (IdxW-1)'($urandom)};
    if (roll < 85) return IdxW'($urandom_range(span));
    return IdxW'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_cmd(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.opcode    <= OpW'($urandom);
      cmd_if.lap_index <= IdxW'($urandom);
      @(negedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.opcode    <= op;
    cmd_if.lap_index <= idx;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  initial begin
    int unsigned kind;
    cmd_if.valid     = 1'b0;
    cmd_if.opcode    = OpTick;
    cmd_if.lap_index = '0;
    res_if.ready     = 1'b0;
    set_phase(0);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Saturation of the elapsed count needs 2**32 ticks and
    // lies outside any practical run.
    send_cmd(OpRead, '1);
    send_cmd(OpRead, '0);
    send_cmd(OpTick, IdxW'(1023));
    send_cmd(OpTick, '1);
    send_cmd(OpRead, '1);
    send_cmd(OpLap, '0);
    send_cmd(OpRead, '0);
    send_cmd(OpRead, IdxW'(1));
    send_cmd(OpRead, IdxW'(1023));
    send_cmd(OpRead, IdxW'(-1024));
    send_cmd(OpRead, IdxW'(-2));
    send_cmd(OpTick, '0);
    send_cmd(OpStop, '0);
    send_cmd(OpTick, '0);
    send_cmd(OpRead, '1);
    send_cmd(OpStop, '1);
    send_cmd(OpLap, '0);
    send_cmd(OpRead, '1);
    send_cmd(OpStart, '0);
    send_cmd(OpTick, '0);
    send_cmd(OpLap, '1);
    send_cmd(OpClear, IdxW'(-1024));
    send_cmd(OpRead, '0);
    send_cmd(OpSpareLo, '1);
    send_cmd(OpSpareHi, IdxW'(1023));

    while (items_sent < ItemTarget) begin
      set_phase((items_sent / 64) % 4);
      kind = $urandom_range(99);
      if (kind < 35) begin
        // A running session with a few laps and reads between them.
        send_cmd(OpStart, pick_index(8));
        repeat ($urandom_range(1, 8)) begin
          repeat ($urandom_range(0, 12)) send_cmd(OpTick, pick_index(63));
          send_cmd(OpLap, pick_index(63));
          if ($urandom_range(1)) send_cmd(OpRead, pick_index(63));
        end
        repeat ($urandom_range(1, 4)) send_cmd(OpRead, pick_index(63));
      end else if (kind < 45) begin
        // Fill the lap store and push past it, then read it back.
        send_cmd(OpClear, pick_index(63));
        send_cmd(OpStart, pick_index(63));
        repeat (LapDepth + 2) begin
          repeat ($urandom_range(0, 3)) send_cmd(OpTick, pick_index(63));
          send_cmd(OpLap, pick_index(63));
        end
        repeat (8) send_cmd(OpRead, pick_index(LapDepth + 1));
      end else if (kind < 70) begin
        // Stop, repeated stop, ticks and a refused lap while stopped.
        repeat ($urandom_range(0, 6)) send_cmd(OpTick, pick_index(63));
        send_cmd(OpStop, pick_index(63));
        if ($urandom_range(1)) send_cmd(OpStop, pick_index(63));
        repeat ($urandom_range(0, 4)) send_cmd(OpTick, pick_index(63));
        send_cmd(OpRead, '1);
        send_cmd(OpLap, pick_index(63));
        send_cmd(OpRead, pick_index(63));
        if ($urandom_range(1)) send_cmd(OpStart, pick_index(63));
      end else if (kind < 77) begin
        send_cmd(OpClear, pick_index(63));
        send_cmd(OpRead, pick_index(63));
      end else begin
        repeat ($urandom_range(1, 10)) send_cmd(OpW'($urandom), IdxW'($urandom));
      end
    end

    cmd_if.valid <= 1'b0;
    set_phase(0);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
